// ===== hdl/mrrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrf_pkg - shared types and constants for the minimum root finder
// Vertex count, widths and sequencer states.
// ----------------------------------------------------------------------------
package mrrf_pkg;
	localparam int MaxNodes = 16;
	localparam int VtxW     = $clog2(MaxNodes);
	localparam int CntW     = $clog2(MaxNodes + 1);

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1_SCAN,
		ST_P1_WALK,
		ST_P2_POP,
		ST_P2_WALK,
		ST_EMIT
	} state_t;
endpackage

// ===== hdl/mrrf_walker.sv =====
// ----------------------------------------------------------------------------
// mrrf_walker - one step of the explicit depth-first walk
// Picks the lowest unvisited neighbour of the stack top or pops it.
// ----------------------------------------------------------------------------
module mrrf_walker
	import mrrf_pkg::*;
(
	input  logic [MaxNodes-1:0] row,
	input  logic [MaxNodes-1:0] mask,
	input  logic [MaxNodes-1:0] visited,
	input  logic [CntW-1:0]     depth,
	output logic                push,
	output logic [VtxW-1:0]     nb
);
	logic [MaxNodes-1:0] cand;

	always_comb begin
		cand = row & mask & ~visited;
		nb   = '0;
		for (int k = MaxNodes - 1; k >= 0; k--) begin
			if (cand[k]) begin
				nb = VtxW'(k);
			end
		end
		push = (cand != '0) && (depth < CntW'(MaxNodes));
	end
endmodule

// ===== hdl/min_reach_root_finder.sv =====
// ----------------------------------------------------------------------------
// min_reach_root_finder - minimum set of start vertices reaching a graph
// Loads adjacency rows, then emits the roots found by two depth-first passes.
// ----------------------------------------------------------------------------
// A search transfer runs a first depth-first pass recording finish order, then
// pops that order and walks from each unvisited vertex, emitting it as a root
// once its walk is done. One shared walk step (one push or pop per cycle) does
// all the work; the block is not ready during a search. With node_count zero
// no result is produced.
// ----------------------------------------------------------------------------
module min_reach_root_finder
	import mrrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row_index[3:0], row_bits[19:4], zero fill
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // root_vertex[3:0], root_ordinal[8:4], zero fill
	output logic        m_tlast
);
	logic [4:0]                 node_count_q;
	logic [MaxNodes-1:0]        adj_q [MaxNodes];
	logic [MaxNodes-1:0]        vis_q, mask_q;
	logic [VtxW-1:0]            fin_q [MaxNodes];
	logic [VtxW-1:0]            stk_q [MaxNodes];
	logic [CntW-1:0]            fcnt_q, depth_q, roots_q;
	logic [CntW-1:0]            scan_q, n_q;
	logic [VtxW-1:0]            rv_q;
	logic [CntW-1:0]            ro_q;
	logic                       rl_q;
	state_t                     state_q, state_d;

	logic [VtxW-1:0] top;
	logic            push;
	logic [VtxW-1:0] nb;
	logic [VtxW-1:0] popv;
	logic [CntW-1:0] depth_m1;
	logic            more;

	assign depth_m1 = depth_q - CntW'(1);
	assign top      = stk_q[depth_m1[VtxW-1:0]];
	assign popv     = fin_q[fcnt_q[VtxW-1:0] - VtxW'(1)];

	mrrf_walker u_walker (
		.row     (adj_q[top]),
		.mask    (mask_q),
		.visited (vis_q),
		.depth   (depth_q),
		.push    (push),
		.nb      (nb)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {7'b0, ro_q, rv_q};
	assign m_tlast  = rl_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (s_tvalid && s_tuser == ACT_SEARCH) state_d = ST_P1_SCAN;
			ST_P1_SCAN:
				if (scan_q >= n_q) state_d = ST_P2_POP;
				else if (!vis_q[scan_q[VtxW-1:0]]) state_d = ST_P1_WALK;
			ST_P1_WALK:
				if (!push && depth_q == CntW'(1)) state_d = ST_P1_SCAN;
			ST_P2_POP:
				if (fcnt_q == '0) state_d = ST_IDLE;
				else if (!vis_q[popv]) state_d = ST_P2_WALK;
			ST_P2_WALK:
				if (!push && depth_q == CntW'(1)) state_d = ST_EMIT;
			ST_EMIT:
				if (m_tready) state_d = ST_P2_POP;
			default: state_d = ST_IDLE;
		endcase
	end

	// the last root is the one whose walk leaves no unvisited finish entries to pop
	always_comb begin
		more = 1'b0;
		for (int k = 0; k < MaxNodes; k++) begin
			if (CntW'(k) < fcnt_q && !vis_q[fin_q[k]]) more = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= 5'd16;
			vis_q        <= '0;
			fcnt_q       <= '0;
			depth_q      <= '0;
			roots_q      <= '0;
			scan_q       <= '0;
			n_q          <= '0;
			mask_q       <= '0;
			rv_q         <= '0;
			ro_q         <= '0;
			rl_q         <= 1'b0;
			for (int i = 0; i < MaxNodes; i++) adj_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) node_count_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tuser == ACT_LOAD) begin
						adj_q[s_tdata[3:0]] <= s_tdata[19:4];
					end else if (s_tvalid) begin
						n_q     <= (node_count_q > 5'(MaxNodes)) ? CntW'(MaxNodes)
						           : CntW'(node_count_q);
						mask_q  <= (node_count_q >= 5'(MaxNodes)) ? '1
						           : MaxNodes'((17'd1 << node_count_q) - 17'd1);
						vis_q   <= '0;
						fcnt_q  <= '0;
						scan_q  <= '0;
						roots_q <= '0;
					end
				end
				ST_P1_SCAN: begin
					if (scan_q < n_q) begin
						if (!vis_q[scan_q[VtxW-1:0]]) begin
							vis_q[scan_q[VtxW-1:0]] <= 1'b1;
							stk_q[0] <= scan_q[VtxW-1:0];
							depth_q  <= CntW'(1);
						end
						scan_q <= scan_q + CntW'(1);
					end else begin
						vis_q <= '0;
					end
				end
				ST_P1_WALK: begin
					if (push) begin
						vis_q[nb] <= 1'b1;
						stk_q[depth_q[VtxW-1:0]] <= nb;
						depth_q <= depth_q + CntW'(1);
					end else begin
						depth_q <= depth_m1;
						if (fcnt_q < CntW'(MaxNodes)) begin
							fin_q[fcnt_q[VtxW-1:0]] <= top;
							fcnt_q <= fcnt_q + CntW'(1);
						end
					end
				end
				ST_P2_POP: begin
					if (fcnt_q != '0) begin
						fcnt_q <= fcnt_q - CntW'(1);
						if (!vis_q[popv]) begin
							vis_q[popv] <= 1'b1;
							stk_q[0]    <= popv;
							depth_q     <= CntW'(1);
							roots_q     <= roots_q + CntW'(1);
							rv_q        <= popv;
							ro_q        <= roots_q + CntW'(1);
						end
					end
				end
				ST_P2_WALK: begin
					if (push) begin
						vis_q[nb] <= 1'b1;
						stk_q[depth_q[VtxW-1:0]] <= nb;
						depth_q <= depth_q + CntW'(1);
					end else begin
						depth_q <= depth_m1;
						if (depth_q == CntW'(1)) rl_q <= !more;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== verif/mrrf_checker.sv =====
// ----------------------------------------------------------------------------
// mrrf_checker - root set predictor and result checker
// Watches both streams, predicts the roots of each search and compares them.
// ----------------------------------------------------------------------------
module mrrf_checker
	import mrrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          roots_pending
);
	typedef struct packed {
		logic [3:0] vertex;
		logic [4:0] ordinal;
		logic       last;
	} root_t;

	logic [15:0] adj_rows [MaxNodes];
	logic [4:0]  vtx_count;
	logic [15:0] seen;
	logic [3:0]  fin_order [MaxNodes];
	int          fin_count;
	root_t       expected_roots [$];

	assign roots_pending = expected_roots.size();

	// Depth-first walk, lowest neighbour first, bounded stack
	task automatic walk(input int start, input logic [15:0] mask, input bit record);
		logic [3:0]  stk [MaxNodes];
		int          depth;
		int          top;
		logic [15:0] cand;
		int          nb;
		depth = 0;
		seen[start] = 1'b1;
		stk[depth++] = start[3:0];
		while (depth > 0) begin
			top = stk[depth-1];
			cand = adj_rows[top] & mask & ~seen;
			if (cand != 0 && depth < MaxNodes) begin
				nb = 0;
				while (!cand[nb]) nb++;
				seen[nb] = 1'b1;
				stk[depth++] = nb[3:0];
			end else begin
				depth--;
				if (record && fin_count < MaxNodes)
					fin_order[fin_count++] = top[3:0];
			end
		end
	endtask

	task automatic predict_roots();
		int          n;
		int          nroots;
		int          v;
		logic [15:0] mask;
		root_t       r;
		n = (vtx_count > MaxNodes) ? MaxNodes : vtx_count;
		mask = (n >= 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
		seen = '0;
		fin_count = 0;
		for (int i = 0; i < n; i++)
			if (!seen[i]) walk(i, mask, 1'b1);
		seen = '0;
		nroots = 0;
		while (fin_count > 0) begin
			v = fin_order[--fin_count];
			if (!seen[v]) begin
				nroots++;
				r.vertex = v[3:0];
				r.ordinal = nroots[4:0];
				r.last = 1'b0;
				expected_roots = {expected_roots, r};
				walk(v, mask, 1'b0);
			end
		end
		if (nroots > 0) expected_roots[$].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		root_t want;
		if (!arst_n) begin
			for (int i = 0; i < MaxNodes; i++) adj_rows[i] = '0;
			vtx_count = 5'd16;
			fail_count = 0;
			expected_roots.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_LOAD) adj_rows[s_tdata[3:0]] = s_tdata[19:4];
				else predict_roots();
			end
			if (cfg_we) vtx_count = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_roots.size() == 0) begin
					$error("unexpected root transfer: vertex %0d", m_tdata[3:0]);
					fail_count++;
				end else begin
					want = expected_roots.pop_front();
					if (m_tdata[3:0] !== want.vertex) begin
						$error("root_vertex: expected %0d, got %0d", want.vertex, m_tdata[3:0]);
						fail_count++;
					end
					if (m_tdata[8:4] !== want.ordinal) begin
						$error("root_ordinal: expected %0d, got %0d",
							want.ordinal, m_tdata[8:4]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the minimum root finder
// Loads random and structured graphs, searches under several vertex counts.
// ----------------------------------------------------------------------------
module tb;
	import mrrf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = ACT_LOAD;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	int          fail_count;
	int          roots_pending;
	int          cycles = 0;
	bit          stim_done = 1'b0;

	localparam int CycleLimit = 400000;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	min_reach_root_finder dut (.*);
	mrrf_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[min_reach_root_finder] ERROR");
			$finish;
		end
	end

	// Receiver: random stall before each result, then hold ready until the transfer
	initial begin
		int gap;
		forever begin
			gap = stim_done ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send(input logic act, input logic [3:0] row, input logic [15:0] bits,
			input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 17);
		repeat (gap) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {4'd0, bits, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (roots_pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic set_count(input logic [4:0] n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [4:0] counts [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2};
		int kind;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Directed: empty graph, full graph, cycle, chain, wide counts
		send(ACT_SEARCH, 4'd0, 16'h0000);
		for (int i = 0; i < 16; i++) send(ACT_LOAD, i[3:0], 16'hFFFF, 1);
		send(ACT_SEARCH, 4'hF, 16'hFFFF);
		for (int i = 0; i < 16; i++)
			send(ACT_LOAD, i[3:0], (i == 15) ? 16'h0001 : (16'd1 << (i + 1)), 1);
		send(ACT_SEARCH, 4'd0, 16'h0000);
		send(ACT_LOAD, 4'd15, 16'h0000);
		send(ACT_SEARCH, 4'd0, 16'h0000);
		// Hold off until every root is out
		drain();
		foreach (counts[c]) begin
			set_count(counts[c]);
			send(ACT_SEARCH, 4'd0, 16'h0000);
		end
		set_count(5'd16);
		// Random: mostly sparse graphs, some dense, some noise
		for (int k = 0; k < 280; k++) begin
			if (k % 70 == 69) set_count(5'($urandom_range(0, 31)));
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send(ACT_LOAD, 4'($urandom_range(0, 15)),
					(16'd1 << $urandom_range(0, 15)) & {16{$urandom_range(0, 3) != 0}});
			end else if (kind < 8) send(ACT_LOAD, 4'($urandom_range(0, 15)), 16'($urandom()));
			else send(ACT_SEARCH, 4'($urandom_range(0, 15)), 16'($urandom()));
		end
		send(ACT_SEARCH, 4'd0, 16'h0000);
		stim_done = 1'b1;
		drain();
		if (fail_count == 0)
			$display("[min_reach_root_finder] OK");
		else
			$display("[min_reach_root_finder] ERROR");
		$finish;
	end
endmodule
